### src/line_raster_bresenham_octant_core_assert.svh
// Assertion macros used by the line rasteriser stepper.
`ifndef LINE_RASTER_BRESENHAM_OCTANT_CORE_ASSERT_SVH
`define LINE_RASTER_BRESENHAM_OCTANT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRBO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRBO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lrbo_pkg.sv
// Types and constants for the line rasteriser.
`timescale 1ns / 1ps

package lrbo_pkg;

    localparam int COORD_W     = 6;
    localparam int OCT_W       = 3;
    localparam int D_W         = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic [OCT_W-1:0]        oct_t;
    typedef logic signed [D_W-1:0]   dec_t;

    // Octant codes: octant number minus one
    localparam oct_t OCT_1 = 3'd0;
    localparam oct_t OCT_2 = 3'd1;
    localparam oct_t OCT_3 = 3'd2;
    localparam oct_t OCT_4 = 3'd3;
    localparam oct_t OCT_5 = 3'd4;
    localparam oct_t OCT_6 = 3'd5;
    localparam oct_t OCT_7 = 3'd6;
    localparam oct_t OCT_8 = 3'd7;

    // Classified line, as handed from front to back
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        logic   neg_x;
        logic   neg_y;
        logic   shallow;
        logic   tie_diag;
        coord_t major;
        coord_t minor;
        oct_t   oct;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

endpackage

### src/lrbo_if.sv
// Handshake interfaces for line requests and pixel words.
`timescale 1ns / 1ps

interface line_req_if;
    logic            valid;
    logic            ready;
    lrbo_pkg::coord_t start_x;
    lrbo_pkg::coord_t start_y;
    lrbo_pkg::coord_t end_x;
    lrbo_pkg::coord_t end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

interface pixel_if;
    logic            valid;
    logic            ready;
    lrbo_pkg::coord_t pixel_x;
    lrbo_pkg::coord_t pixel_y;
    lrbo_pkg::oct_t   octant_index;
    logic            last_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output octant_index, output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input octant_index, input last_pixel, output ready);
endinterface

### src/lrbo_front.sv
// Request front end: clamps endpoints and classifies the line by octant.
`timescale 1ns / 1ps

module lrbo_front #(
    parameter int TILE_SIZE = 64
) (
    line_req_if.sink        req,
    input  logic            full,
    output lrbo_pkg::push_t push
);
    import lrbo_pkg::*;

    localparam coord_t COORD_MAX = COORD_W'(TILE_SIZE - 1);

    coord_t             x0, y0, x1, y1;
    logic [COORD_W:0]   dx, dy;
    logic               neg_x, neg_y, shallow;
    coord_t             ax, ay;
    oct_t               oct;

    function automatic coord_t clamp(input coord_t c);
        return (c > COORD_MAX) ? COORD_MAX : c;
    endfunction

    always_comb
    begin
        x0    = clamp(req.start_x);
        y0    = clamp(req.start_y);
        x1    = clamp(req.end_x);
        y1    = clamp(req.end_y);
        dx    = {1'b0, x1} - {1'b0, x0};
        dy    = {1'b0, y1} - {1'b0, y0};
        neg_x = dx[COORD_W];
        neg_y = dy[COORD_W];
        ax    = neg_x ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ay    = neg_y ? COORD_W'(-dy) : dy[COORD_W-1:0];
        shallow = (ax >= ay);

        if (shallow)
        begin
            oct = !neg_x ? (!neg_y ? OCT_1 : OCT_8) : (!neg_y ? OCT_4 : OCT_5);
        end
        else
        begin
            oct = !neg_y ? (!neg_x ? OCT_2 : OCT_3) : (!neg_x ? OCT_7 : OCT_6);
        end

        push.valid        = req.valid && !full;
        push.job.x0       = x0;
        push.job.y0       = y0;
        push.job.neg_x    = neg_x;
        push.job.neg_y    = neg_y;
        push.job.shallow  = shallow;
        push.job.tie_diag = (oct == OCT_2) || (oct == OCT_4) ||
                            (oct == OCT_6) || (oct == OCT_7);
        push.job.major    = shallow ? ax : ay;
        push.job.minor    = shallow ? ay : ax;
        push.job.oct      = oct;
    end

    assign req.ready = !full;

endmodule

### src/lrbo_queue.sv
// Short queue of classified lines between front end and stepper.
`timescale 1ns / 1ps

module lrbo_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  lrbo_pkg::push_t push,
    output logic            full,
    input  logic            pop,
    output lrbo_pkg::head_t head
);
    import lrbo_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

### src/lrbo_back.sv
// Line stepper: walks the decision variable and emits one pixel per word.
`timescale 1ns / 1ps

`include "line_raster_bresenham_octant_core_assert.svh"

module lrbo_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lrbo_pkg::head_t head,
    output logic            pop,
    pixel_if.source         pix
);
    import lrbo_pkg::*;

    logic    busy_reg;
    logic    pix_valid_reg;
    job_t    job_reg;
    coord_t  x_reg, y_reg, remain_reg;
    dec_t    d_reg;
    coord_t  px_reg, py_reg;
    oct_t    poct_reg;
    logic    plast_reg;

    logic    out_ok, emit, diag, step_x, step_y;
    dec_t    d_init, inc_axial, inc_diag;

    assign out_ok = !pix_valid_reg || pix.ready;
    assign emit   = busy_reg && out_ok;
    assign pop    = !busy_reg && head.valid;

    always_comb
    begin
        d_init    = dec_t'({2'b00, head.job.minor, 1'b0}) - dec_t'({3'b000, head.job.major});
        inc_axial = dec_t'({2'b00, job_reg.minor, 1'b0});
        inc_diag  = inc_axial - dec_t'({2'b00, job_reg.major, 1'b0});
        // Diagonal on a positive decision, or on a tie in octants 2, 4, 6 and 7
        diag   = (!d_reg[D_W-1] && (d_reg != '0)) || ((d_reg == '0) && job_reg.tie_diag);
        step_x = job_reg.shallow || diag;
        step_y = !job_reg.shallow || diag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && (remain_reg == '0))
            begin
                busy_reg <= 1'b0;
            end

            if (emit)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg    <= head.job;
            x_reg      <= head.job.x0;
            y_reg      <= head.job.y0;
            remain_reg <= head.job.major;
            d_reg      <= d_init;
        end
        else if (emit)
        begin
            // Advance to the next pixel; the value after the end point is never shown
            if (step_x)
            begin
                x_reg <= job_reg.neg_x ? x_reg - 1'b1 : x_reg + 1'b1;
            end
            if (step_y)
            begin
                y_reg <= job_reg.neg_y ? y_reg - 1'b1 : y_reg + 1'b1;
            end
            d_reg      <= d_reg + (diag ? inc_diag : inc_axial);
            remain_reg <= remain_reg - 1'b1;
        end

        if (emit)
        begin
            px_reg    <= x_reg;
            py_reg    <= y_reg;
            poct_reg  <= job_reg.oct;
            plast_reg <= (remain_reg == '0);
        end
    end

    assign pix.valid        = pix_valid_reg;
    assign pix.pixel_x      = px_reg;
    assign pix.pixel_y      = py_reg;
    assign pix.octant_index = poct_reg;
    assign pix.last_pixel   = plast_reg;

    `LRBO_ASSERT_NEXT(a_end_frees_stepper, emit && (remain_reg == '0), !busy_reg, "stepper still busy after end point")
    `LRBO_ASSERT_NEXT(a_emit_marks_last, emit, plast_reg == ($past(remain_reg) == '0), "end mark out of step with pixel count")
    `LRBO_ASSERT_NEXT(a_major_x_moves, emit && (remain_reg != '0) && job_reg.shallow, x_reg != $past(x_reg), "major x axis failed to advance")
    `LRBO_ASSERT_NEXT(a_major_y_moves, emit && (remain_reg != '0) && !job_reg.shallow, y_reg != $past(y_reg), "major y axis failed to advance")

endmodule

### src/line_raster_bresenham_octant_core.sv
// Top level of the octant line rasteriser: front end, queue and stepper.
// A request is written into the queue, loaded into the stepper, and each pixel word is
// registered at the output. The single stepper loads a new line only once the last is
// done, then emits one pixel per cycle unless stalled; up to two requests wait queued.
// Reset: rst_n clears the queue, the stepper and the pixel valid; no item is in flight.
`timescale 1ns / 1ps

module line_raster_bresenham_octant_core #(
    parameter int TILE_SIZE = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    line_req_if.sink   req,
    pixel_if.source    pix
);
    import lrbo_pkg::*;

    push_t push;
    head_t head;
    logic  full;
    logic  pop;

    lrbo_front #(
        .TILE_SIZE (TILE_SIZE)
    ) u_front (
        .req  (req),
        .full (full),
        .push (push)
    );

    lrbo_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    lrbo_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .pix   (pix)
    );

endmodule

### dv/line_raster_bresenham_octant_core_tb.sv
// Self-checking testbench for the octant line rasteriser: random handshakes, pixel prediction.
`timescale 1ns / 1ps

module line_raster_bresenham_octant_core_tb;

    import lrbo_pkg::*;

    localparam int TILE         = 64;
    localparam int RANDOM_LINES = 450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 18;
    localparam int CALM_FROM    = 4000;
    localparam int CALM_TO      = 8000;
    localparam int HOLD_AT      = 1500;
    localparam int HOLD_LEN     = 400;

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        bit     drain_first;
    } line_req_t;

    typedef struct {
        coord_t px;
        coord_t py;
        oct_t   oct;
        logic   last;
    } pixel_word_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   fail_count;
    int   hold_left;
    logic gaps_on;

    line_req_t   pending_lines[$];
    line_req_t   cur_line;
    pixel_word_t pixel_expect[$];
    pixel_word_t want;

    line_req_if line_bus ();
    pixel_if    pixel_bus ();

    line_raster_bresenham_octant_core #(.TILE_SIZE(TILE)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (line_bus),
        .pix   (pixel_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    assign gaps_on = !(cycles >= CALM_FROM && cycles < CALM_TO);

    function automatic int clamp_coord(coord_t c);
        return (int'(c) > TILE - 1) ? TILE - 1 : int'(c);
    endfunction

    // Walk the line with the doubled-delta decision and queue every pixel word.
    function automatic void rasterise_line(line_req_t l);
        int x0, y0, x1, y1, dx, dy, ax, ay, sx, sy;
        int major, minor, dec, x, y;
        bit shallow, diag_on_tie;
        oct_t oct;
        pixel_word_t w;
        x0 = clamp_coord(l.sx);
        y0 = clamp_coord(l.sy);
        x1 = clamp_coord(l.ex);
        y1 = clamp_coord(l.ey);
        dx = x1 - x0;
        dy = y1 - y0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sx = (dx < 0) ? -1 : 1;
        sy = (dy < 0) ? -1 : 1;
        shallow = (ax >= ay);
        if (shallow)
            oct = (dx >= 0) ? ((dy >= 0) ? OCT_1 : OCT_8) : ((dy >= 0) ? OCT_4 : OCT_5);
        else
            oct = (dy >= 0) ? ((dx >= 0) ? OCT_2 : OCT_3) : ((dx >= 0) ? OCT_7 : OCT_6);
        diag_on_tie = (oct == OCT_2 || oct == OCT_4 || oct == OCT_6 || oct == OCT_7);
        major = shallow ? ax : ay;
        minor = shallow ? ay : ax;
        dec = 2 * minor - major;
        x = x0;
        y = y0;
        for (int k = 0; k <= major; k++)
        begin
            w.px   = coord_t'(x);
            w.py   = coord_t'(y);
            w.oct  = oct;
            w.last = (k == major);
            pixel_expect.push_back(w);
            if (dec > 0 || (dec == 0 && diag_on_tie))
            begin
                if (shallow) y += sy; else x += sx;
                dec += 2 * (minor - major);
            end
            else
            begin
                dec += 2 * minor;
            end
            if (shallow) x += sx; else y += sy;
        end
    endfunction

    function automatic void add_line(int sx, int sy, int ex, int ey, bit drain_first);
        line_req_t l;
        l.sx = coord_t'(sx);
        l.sy = coord_t'(sy);
        l.ex = coord_t'(ex);
        l.ey = coord_t'(ey);
        l.drain_first = drain_first;
        pending_lines.push_back(l);
    endfunction

    function automatic int near_coord(int c);
        int n;
        n = c + $urandom_range(14) - 7;
        if (n < 0) n = 0;
        if (n > TILE - 1) n = TILE - 1;
        return n;
    endfunction

    // Request driver: present the next queued line once the previous word is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (line_bus.valid && line_bus.ready)
                rasterise_line(cur_line);
            if (!line_bus.valid || line_bus.ready)
            begin
                if (pending_lines.size() > 0
                    && !(gaps_on && $urandom_range(99) < IDLE_PCT)
                    && !(pending_lines[0].drain_first && pixel_expect.size() > 0))
                begin
                    cur_line = pending_lines.pop_front();
                    line_bus.valid   <= 1'b1;
                    line_bus.start_x <= cur_line.sx;
                    line_bus.start_y <= cur_line.sy;
                    line_bus.end_x   <= cur_line.ex;
                    line_bus.end_y   <= cur_line.ey;
                end
                else
                begin
                    line_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor: check each accepted word, then choose ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_bus.valid && pixel_bus.ready)
            begin
                if (pixel_expect.size() == 0)
                begin
                    $error("unexpected pixel word x=%0d y=%0d", pixel_bus.pixel_x,
                           pixel_bus.pixel_y);
                    fail_count++;
                end
                else
                begin
                    want = pixel_expect.pop_front();
                    if (pixel_bus.pixel_x !== want.px)
                    begin
                        $error("pixel_x: expected %0d, actual %0d", want.px, pixel_bus.pixel_x);
                        fail_count++;
                    end
                    if (pixel_bus.pixel_y !== want.py)
                    begin
                        $error("pixel_y: expected %0d, actual %0d", want.py, pixel_bus.pixel_y);
                        fail_count++;
                    end
                    if (pixel_bus.octant_index !== want.oct)
                    begin
                        $error("octant_index: expected %0d, actual %0d", want.oct,
                               pixel_bus.octant_index);
                        fail_count++;
                    end
                    if (pixel_bus.last_pixel !== want.last)
                    begin
                        $error("last_pixel: expected %0d, actual %0d", want.last,
                               pixel_bus.last_pixel);
                        fail_count++;
                    end
                end
            end
            // hold off for a long stretch so the request side backs up
            if (cycles == HOLD_AT)
                hold_left = HOLD_LEN;
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_bus.ready <= 1'b0;
            end
            else
            begin
                pixel_bus.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int sx, sy, ex, ey, kind;
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        fail_count = 0;
        hold_left = 0;
        line_bus.valid   = 1'b0;
        line_bus.start_x = '0;
        line_bus.start_y = '0;
        line_bus.end_x   = '0;
        line_bus.end_y   = '0;
        pixel_bus.ready  = 1'b0;

        // zero length, axial, diagonal and corner-to-corner lines
        add_line(0, 0, 0, 0, 1'b0);
        add_line(63, 63, 63, 63, 1'b0);
        add_line(0, 0, 63, 0, 1'b0);
        add_line(63, 5, 0, 5, 1'b0);
        add_line(3, 0, 3, 63, 1'b0);
        add_line(10, 63, 10, 0, 1'b0);
        add_line(0, 0, 63, 63, 1'b0);
        add_line(63, 0, 0, 63, 1'b0);
        add_line(63, 63, 0, 0, 1'b0);
        add_line(0, 63, 63, 0, 1'b0);
        // a tie on the first step, once in each octant
        add_line(30, 30, 34, 32, 1'b0);
        add_line(30, 30, 32, 34, 1'b0);
        add_line(30, 30, 28, 34, 1'b0);
        add_line(30, 30, 26, 32, 1'b0);
        add_line(30, 30, 26, 28, 1'b0);
        add_line(30, 30, 28, 26, 1'b0);
        add_line(30, 30, 32, 26, 1'b0);
        add_line(30, 30, 34, 28, 1'b0);
        // near-axial extremes
        add_line(0, 63, 63, 62, 1'b0);
        add_line(63, 0, 0, 1, 1'b0);
        add_line(0, 0, 1, 63, 1'b0);
        add_line(62, 63, 63, 0, 1'b0);

        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            sx = $urandom_range(TILE - 1);
            sy = $urandom_range(TILE - 1);
            kind = $urandom_range(99);
            if (kind < 50)
            begin
                ex = $urandom_range(TILE - 1);
                ey = $urandom_range(TILE - 1);
            end
            else if (kind < 85)
            begin
                ex = near_coord(sx);
                ey = near_coord(sy);
            end
            else
            begin
                // axial or exact diagonal
                ex = $urandom_range(TILE - 1);
                case ($urandom_range(2))
                    0: ey = sy;
                    1: begin ey = $urandom_range(TILE - 1); ex = sx; end
                    default:
                    begin
                        ey = sy + ((ex >= sx) ? ex - sx : sx - ex)
                                  * ($urandom_range(1) ? 1 : -1);
                        if (ey < 0 || ey > TILE - 1) ey = sy;
                    end
                endcase
            end
            add_line(sx, sy, ex, ey, (i == 0 || i == 220));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge so the driver's updates have settled
        while (pending_lines.size() > 0 || line_bus.valid)
            @(negedge clk);
        while (pixel_expect.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pixel_expect.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
